// ----- rtl/core/mp3si_pkg.sv -----
// Shared constants, types and codes of the layer III side-information parser.
package mp3si_pkg;

    localparam int REC_W   = 63;
    localparam int POS_W   = 6;
    localparam int FF_W    = 14;

    // Section lengths in bits.
    localparam logic [POS_W-1:0] HDR_LEN_M1_MONO    = 6'd18;
    localparam logic [POS_W-1:0] HDR_LEN_M1_STEREO  = 6'd20;
    localparam logic [POS_W-1:0] HDR_LEN_LSF_MONO   = 6'd9;
    localparam logic [POS_W-1:0] HDR_LEN_LSF_STEREO = 6'd10;
    localparam logic [POS_W-1:0] REC_LEN_M1         = 6'd59;
    localparam logic [POS_W-1:0] REC_LEN_LSF        = 6'd63;
    localparam logic [POS_W-1:0] WORD_BITS          = 6'd8;

    // Frame layout codes: {mpeg1, mono}.
    localparam logic [1:0] LAYOUT_LSF_STEREO = 2'b00;
    localparam logic [1:0] LAYOUT_LSF_MONO   = 2'b01;
    localparam logic [1:0] LAYOUT_M1_STEREO  = 2'b10;
    localparam logic [1:0] LAYOUT_M1_MONO    = 2'b11;

    localparam logic [8:0] GAIN_OFFSET = 9'd210;

    localparam logic [1:0] BT_RESERVED = 2'd0;
    localparam logic [1:0] BT_SHORT    = 2'd2;

    localparam logic [3:0] RC_SHORT_R0 = 4'd8;
    localparam logic [3:0] RC_SHORT_R1 = 4'd12;
    localparam logic [3:0] RC_LONG_R0  = 4'd7;
    localparam logic [3:0] RC_LONG_R1  = 4'd13;

    localparam logic [1:0] STATUS_RECORD = 2'd0;
    localparam logic [1:0] STATUS_LAST   = 2'd1;
    localparam logic [1:0] STATUS_ERROR  = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        FS_HALTED,
        FS_HEADER,
        FS_RECORDS
    } t_front_state;

    // One completed record section with the context the decoder needs.
    typedef struct packed {
        logic [REC_W-1:0] bits;
        logic             mpeg1;
        logic             err;
        logic             last;
        logic [1:0]       idx;
        logic [3:0]       scfsi;
        logic [FF_W-1:0]  ff;
    } t_rec_entry;

endpackage

// ----- rtl/core/mp3si_front.sv -----
// Front end: accepts side-information words, slices bits and classifies completed records.
module mp3si_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_frame_start,
    input  logic                   i_is_mono,
    input  logic                   i_is_mpeg1,
    input  logic                   i_full,
    output logic                   o_ready,
    output logic                   o_push,
    output mp3si_pkg::t_rec_entry  o_entry
);

    mp3si_pkg::t_front_state             r_state, n_state, c_state;
    logic [mp3si_pkg::POS_W-1:0]         r_pos, n_pos, c_pos;
    logic [mp3si_pkg::REC_W-1:0]         r_bits, n_bits, c_bits;
    logic [1:0]                          r_cnt, n_cnt, c_cnt;
    logic                                r_mono, n_mono, c_mono;
    logic                                r_mpeg1, n_mpeg1, c_mpeg1;
    logic [mp3si_pkg::FF_W-1:0]          r_ff, n_ff, c_ff;
    logic [7:0]                          r_scfsi, n_scfsi;

    logic                                accept;
    logic [1:0]                          layout;
    logic [mp3si_pkg::POS_W-1:0]         hdr_len, seg_len, need;
    logic                                fits;
    logic [2:0]                          shamt;
    logic [mp3si_pkg::REC_W+7:0]         shifted;
    logic [mp3si_pkg::REC_W-1:0]         word;
    logic [7:0]                          rest;
    logic                                rec_err, rec_last, chan;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mp3si_pkg::FS_HALTED;
            r_pos   <= '0;
            r_bits  <= '0;
            r_cnt   <= '0;
            r_mono  <= 1'b0;
            r_mpeg1 <= 1'b1;
            r_ff    <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_bits  <= n_bits;
            r_cnt   <= n_cnt;
            r_mono  <= n_mono;
            r_mpeg1 <= n_mpeg1;
            r_ff    <= n_ff;
        end
    end

    // The scfsi bits are always written by the header before a record reads them.
    always_ff @(posedge i_clk) begin
        r_scfsi <= n_scfsi;
    end

    always_comb begin
        // A frame start restarts parsing with the new flags before this word is sliced.
        c_state = r_state;
        c_pos   = r_pos;
        c_bits  = r_bits;
        c_cnt   = r_cnt;
        c_mono  = r_mono;
        c_mpeg1 = r_mpeg1;
        c_ff    = r_ff;
        if (i_frame_start) begin
            c_state = mp3si_pkg::FS_HEADER;
            c_pos   = '0;
            c_bits  = '0;
            c_cnt   = '0;
            c_mono  = i_is_mono;
            c_mpeg1 = i_is_mpeg1;
            c_ff    = '0;
        end

        layout = {c_mpeg1, c_mono};
        case (layout)
            mp3si_pkg::LAYOUT_M1_MONO:    hdr_len = mp3si_pkg::HDR_LEN_M1_MONO;
            mp3si_pkg::LAYOUT_M1_STEREO:  hdr_len = mp3si_pkg::HDR_LEN_M1_STEREO;
            mp3si_pkg::LAYOUT_LSF_MONO:   hdr_len = mp3si_pkg::HDR_LEN_LSF_MONO;
            mp3si_pkg::LAYOUT_LSF_STEREO: hdr_len = mp3si_pkg::HDR_LEN_LSF_STEREO;
            default:                      hdr_len = mp3si_pkg::HDR_LEN_M1_STEREO;
        endcase

        if (c_state == mp3si_pkg::FS_HEADER) begin
            seg_len = hdr_len;
        end else begin
            seg_len = c_mpeg1 ? mp3si_pkg::REC_LEN_M1 : mp3si_pkg::REC_LEN_LSF;
        end
        need = seg_len - c_pos;
        fits = (need <= mp3si_pkg::WORD_BITS);
        // When the section ends inside this word, the low bits left over start the next one.
        shamt   = fits ? 3'(mp3si_pkg::WORD_BITS - need) : 3'd0;
        shifted = {c_bits, i_data_byte} >> shamt;
        word    = shifted[mp3si_pkg::REC_W-1:0];
        rest    = i_data_byte & ~(8'hFF << shamt);

        if (c_mpeg1) begin
            rec_err = word[25] && (word[24:23] == mp3si_pkg::BT_RESERVED);
        end else begin
            rec_err = word[24] && (word[23:22] == mp3si_pkg::BT_RESERVED);
        end
        case (layout)
            mp3si_pkg::LAYOUT_M1_MONO:    rec_last = (c_cnt == 2'd1);
            mp3si_pkg::LAYOUT_M1_STEREO:  rec_last = (c_cnt == 2'd3);
            mp3si_pkg::LAYOUT_LSF_MONO:   rec_last = 1'b1;
            mp3si_pkg::LAYOUT_LSF_STEREO: rec_last = (c_cnt == 2'd1);
            default:                      rec_last = 1'b1;
        endcase
        chan = c_mpeg1 && !c_mono && c_cnt[0];

        o_entry.bits  = word;
        o_entry.mpeg1 = c_mpeg1;
        o_entry.err   = rec_err;
        o_entry.last  = rec_last;
        o_entry.idx   = (c_mpeg1 && c_mono) ? {c_cnt[0], 1'b0} : c_cnt;
        o_entry.scfsi = chan ? r_scfsi[7:4] : r_scfsi[3:0];
        o_entry.ff    = r_ff;

        o_push  = 1'b0;
        n_state = r_state;
        n_pos   = r_pos;
        n_bits  = r_bits;
        n_cnt   = r_cnt;
        n_mono  = r_mono;
        n_mpeg1 = r_mpeg1;
        n_ff    = r_ff;
        n_scfsi = r_scfsi;

        if (accept) begin
            n_state = c_state;
            n_pos   = c_pos;
            n_bits  = c_bits;
            n_cnt   = c_cnt;
            n_mono  = c_mono;
            n_mpeg1 = c_mpeg1;
            n_ff    = c_ff;
            case (c_state)
                mp3si_pkg::FS_HEADER: begin
                    if (fits) begin
                        case (layout)
                            mp3si_pkg::LAYOUT_M1_MONO: begin
                                n_ff    = {word[17:9], word[8:4]};
                                n_scfsi = {4'd0, word[3:0]};
                            end
                            mp3si_pkg::LAYOUT_M1_STEREO: begin
                                n_ff    = {word[19:11], 2'd0, word[10:8]};
                                n_scfsi = {word[3:0], word[7:4]};
                            end
                            mp3si_pkg::LAYOUT_LSF_MONO: begin
                                n_ff    = {1'b0, word[8:1], 4'd0, word[0]};
                                n_scfsi = 8'd0;
                            end
                            default: begin
                                n_ff    = {1'b0, word[9:2], 3'd0, word[1:0]};
                                n_scfsi = 8'd0;
                            end
                        endcase
                        n_state = mp3si_pkg::FS_RECORDS;
                        n_bits  = {{(mp3si_pkg::REC_W-8){1'b0}}, rest};
                        n_pos   = {{(mp3si_pkg::POS_W-3){1'b0}}, shamt};
                    end else begin
                        n_bits = word;
                        n_pos  = c_pos + mp3si_pkg::WORD_BITS;
                    end
                end
                mp3si_pkg::FS_RECORDS: begin
                    if (fits) begin
                        o_push = 1'b1;
                        if (rec_err || rec_last) begin
                            n_state = mp3si_pkg::FS_HALTED;
                        end else begin
                            n_cnt  = c_cnt + 2'd1;
                            n_bits = {{(mp3si_pkg::REC_W-8){1'b0}}, rest};
                            n_pos  = {{(mp3si_pkg::POS_W-3){1'b0}}, shamt};
                        end
                    end else begin
                        n_bits = word;
                        n_pos  = c_pos + mp3si_pkg::WORD_BITS;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_valid && !i_full))
        else $error("record pushed without an accepted word");

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mp3si_pkg::FS_HALTED && !i_frame_start) |-> !o_push)
        else $error("record pushed while halted");

endmodule

// ----- rtl/core/mp3si_queue.sv -----
// Short register queue between the slicing front end and the decoding back end.
module mp3si_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  mp3si_pkg::t_rec_entry  i_entry,
    input  logic                   i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output mp3si_pkg::t_rec_entry  o_entry
);

    mp3si_pkg::t_rec_entry                r_mem [mp3si_pkg::QUEUE_DEPTH];
    logic [mp3si_pkg::QUEUE_AW-1:0]       r_wptr, n_wptr, r_rptr, n_rptr;
    logic [mp3si_pkg::QUEUE_CW-1:0]       r_count, n_count;

    localparam logic [mp3si_pkg::QUEUE_AW-1:0] LastSlot =
        mp3si_pkg::QUEUE_AW'(mp3si_pkg::QUEUE_DEPTH - 1);
    localparam logic [mp3si_pkg::QUEUE_CW-1:0] FullCount =
        mp3si_pkg::QUEUE_CW'(mp3si_pkg::QUEUE_DEPTH);

    assign o_full  = (r_count == FullCount);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == LastSlot) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LastSlot) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCount)
        else $error("queue count beyond depth");

endmodule

// ----- rtl/core/mp3si_back.sv -----
// Back end: decodes queued record sections into output fields behind an output register.
module mp3si_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  mp3si_pkg::t_rec_entry  i_entry,
    output logic                   o_pop,
    input  logic                   i_ready,
    output logic                   o_valid,
    output logic [1:0]             o_record_index,
    output logic [11:0]            o_part23_length,
    output logic [8:0]             o_bigval_pairs,
    output logic signed [8:0]      o_gain_adj,
    output logic [8:0]             o_sf_compress,
    output logic [3:0]             o_block_info,
    output logic [14:0]            o_table_selects,
    output logic [8:0]             o_subblock_gains,
    output logic [7:0]             o_region_counts,
    output logic [6:0]             o_granule_flags,
    output logic [13:0]            o_frame_fields,
    output logic [1:0]             o_status
);

    logic        r_valid;
    logic [1:0]  r_idx;
    logic [11:0] r_part;
    logic [8:0]  r_big;
    logic [8:0]  r_gain;
    logic [8:0]  r_sfc;
    logic [3:0]  r_info;
    logic [14:0] r_ts;
    logic [8:0]  r_sg;
    logic [7:0]  r_rc;
    logic [6:0]  r_flags;
    logic [13:0] r_ff;
    logic [1:0]  r_status;

    logic [mp3si_pkg::REC_W-1:0] rb;
    logic [11:0] d_part;
    logic [8:0]  d_big, d_gain, d_sfc, d_sg;
    logic [7:0]  gain8;
    logic        ws, pre;
    logic [21:0] blk;
    logic [1:0]  bt;
    logic        mixed;
    logic [3:0]  d_info;
    logic [14:0] d_ts;
    logic [7:0]  d_rc;
    logic [6:0]  d_flags;
    logic [1:0]  d_status;

    assign o_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        rb = i_entry.bits;
        if (i_entry.mpeg1) begin
            d_part = rb[58:47];
            d_big  = rb[46:38];
            gain8  = rb[37:30];
            d_sfc  = {5'd0, rb[29:26]};
            ws     = rb[25];
            blk    = rb[24:3];
            pre    = rb[2];
        end else begin
            d_part = rb[62:51];
            d_big  = rb[50:42];
            gain8  = rb[41:34];
            d_sfc  = rb[33:25];
            ws     = rb[24];
            blk    = rb[23:2];
            pre    = 1'b0;
        end
        bt    = blk[21:20];
        mixed = blk[19];
        if (ws) begin
            d_info = {1'b1, bt, mixed};
            d_ts   = {blk[18:14], blk[13:9], 5'd0};
            d_sg   = blk[8:0];
            // Region counts are implied for switched blocks.
            if (bt == mp3si_pkg::BT_SHORT && !mixed) begin
                d_rc = {mp3si_pkg::RC_SHORT_R0, mp3si_pkg::RC_SHORT_R1};
            end else begin
                d_rc = {mp3si_pkg::RC_LONG_R0, mp3si_pkg::RC_LONG_R1};
            end
        end else begin
            d_info = 4'd0;
            d_ts   = blk[21:7];
            d_sg   = 9'd0;
            d_rc   = {blk[6:3], 1'b0, blk[2:0]};
        end
        d_gain   = {1'b0, gain8} - mp3si_pkg::GAIN_OFFSET;
        d_flags  = {i_entry.scfsi, pre, rb[1], rb[0]};
        d_status = i_entry.last ? mp3si_pkg::STATUS_LAST : mp3si_pkg::STATUS_RECORD;
        // An error record keeps only its index and frame fields.
        if (i_entry.err) begin
            d_part   = '0;
            d_big    = '0;
            d_gain   = '0;
            d_sfc    = '0;
            d_info   = '0;
            d_ts     = '0;
            d_sg     = '0;
            d_rc     = '0;
            d_flags  = '0;
            d_status = mp3si_pkg::STATUS_ERROR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_idx    <= i_entry.idx;
            r_part   <= d_part;
            r_big    <= d_big;
            r_gain   <= d_gain;
            r_sfc    <= d_sfc;
            r_info   <= d_info;
            r_ts     <= d_ts;
            r_sg     <= d_sg;
            r_rc     <= d_rc;
            r_flags  <= d_flags;
            r_ff     <= i_entry.ff;
            r_status <= d_status;
        end
    end

    assign o_valid          = r_valid;
    assign o_record_index   = r_idx;
    assign o_part23_length  = r_part;
    assign o_bigval_pairs   = r_big;
    assign o_gain_adj       = $signed(r_gain);
    assign o_sf_compress    = r_sfc;
    assign o_block_info     = r_info;
    assign o_table_selects  = r_ts;
    assign o_subblock_gains = r_sg;
    assign o_region_counts  = r_rc;
    assign o_granule_flags  = r_flags;
    assign o_frame_fields   = r_ff;
    assign o_status         = r_status;

    a_error_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == mp3si_pkg::STATUS_ERROR) |->
        (o_part23_length == '0 && o_bigval_pairs == '0 && o_block_info == '0 &&
         o_granule_flags == '0 && o_region_counts == '0))
        else $error("error word carries decoded fields");

    a_switched_third_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_block_info[3]) |-> (o_table_selects[4:0] == '0))
        else $error("switched block with a third table select");

endmodule

// ----- rtl/core/mp3_side_info_parser.sv -----
// A record completed by a word is pushed into the queue when the word is accepted and
// reaches the outputs through the back end's output register. Throughput: one
// side-information word per cycle while the queue is not full; at most one record is
// produced per word. The front end slices bits combinationally and a two-entry queue
// feeds the decoding back end. Reset (synchronous, active low) empties the queue and
// output register and leaves the parser halted until a word marked as frame start arrives.
module mp3_side_info_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_start,
    input  logic               i_is_mono,
    input  logic               i_is_mpeg1,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_record_index,
    output logic [11:0]        o_part23_length,
    output logic [8:0]         o_bigval_pairs,
    output logic signed [8:0]  o_gain_adj,
    output logic [8:0]         o_sf_compress,
    output logic [3:0]         o_block_info,
    output logic [14:0]        o_table_selects,
    output logic [8:0]         o_subblock_gains,
    output logic [7:0]         o_region_counts,
    output logic [6:0]         o_granule_flags,
    output logic [13:0]        o_frame_fields,
    output logic [1:0]         o_status
);

    logic                   q_full, q_valid, push, pop;
    mp3si_pkg::t_rec_entry  push_entry, head_entry;

    mp3si_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .i_is_mono     (i_is_mono),
        .i_is_mpeg1    (i_is_mpeg1),
        .i_full        (q_full),
        .o_ready       (o_ready),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    mp3si_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    mp3si_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_entry          (head_entry),
        .o_pop            (pop),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_record_index   (o_record_index),
        .o_part23_length  (o_part23_length),
        .o_bigval_pairs   (o_bigval_pairs),
        .o_gain_adj       (o_gain_adj),
        .o_sf_compress    (o_sf_compress),
        .o_block_info     (o_block_info),
        .o_table_selects  (o_table_selects),
        .o_subblock_gains (o_subblock_gains),
        .o_region_counts  (o_region_counts),
        .o_granule_flags  (o_granule_flags),
        .o_frame_fields   (o_frame_fields),
        .o_status         (o_status)
    );

endmodule

// ----- bench/tb_mp3_side_info_parser.sv -----
// Self-checking testbench for the layer III side-information parser.
`timescale 1ns / 1ps

module tb_mp3_side_info_parser;

    localparam int          TARGET_WORDS = 1000;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          IDLE_PCT     = 18;

    // How the bits of a generated frame are filled.
    localparam int FILL_ZERO  = 0;
    localparam int FILL_ONES  = 1;
    localparam int FILL_LEGAL = 2;   // random, reserved switched blocks avoided
    localparam int FILL_RAW   = 3;   // random, anything goes

    localparam int NO_ERROR = -1;
    localparam int WHOLE    = 64;

    typedef struct packed {
        logic [1:0]  idx;
        logic [11:0] part23;
        logic [8:0]  big_vals;
        logic [8:0]  gain;
        logic [8:0]  sf_compress;
        logic [3:0]  blk_info;
        logic [14:0] tables;
        logic [8:0]  sub_gains;
        logic [7:0]  regions;
        logic [6:0]  gflags;
        logic [13:0] ffields;
        logic [1:0]  status;
    } t_granule_rec;

    class t_granule_scoreboard;
        int unsigned  bit_pos;
        logic [63:0]  sect_bits;
        logic [13:0]  ff_store;
        logic [7:0]   scfsi;
        logic [1:0]   rec_cnt;
        bit           in_recs;
        bit           mono;
        bit           mpeg1;
        bit           halted;
        t_granule_rec expected_q[$];
        int           errors;

        function new();
            bit_pos   = 0;
            sect_bits = '0;
            ff_store  = '0;
            scfsi     = '0;
            rec_cnt   = '0;
            in_recs   = 1'b0;
            mono      = 1'b0;
            mpeg1     = 1'b1;
            halted    = 1'b1;
            errors    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Notes an accepted word; returns 1 when the parser actually consumed it.
        function bit note_word(logic [7:0] b, logic fs, logic m, logic m1);
            int unsigned  hdr_len, rec_len, total;
            int           i;
            bit           consumed, emitted, chan;
            logic [63:0]  h;
            logic [21:0]  blk;
            logic [1:0]   bt;
            logic         ws, mixed, pre, scale, c1;
            logic [7:0]   gain8;
            t_granule_rec rec;
            if (fs) begin
                mono      = m;
                mpeg1     = m1;
                bit_pos   = 0;
                sect_bits = '0;
                ff_store  = '0;
                scfsi     = '0;
                rec_cnt   = '0;
                in_recs   = 1'b0;
                halted    = 1'b0;
            end
            consumed = !halted;
            emitted  = 1'b0;
            case ({mpeg1, mono})
                mp3si_pkg::LAYOUT_M1_MONO:   hdr_len = mp3si_pkg::HDR_LEN_M1_MONO;
                mp3si_pkg::LAYOUT_M1_STEREO: hdr_len = mp3si_pkg::HDR_LEN_M1_STEREO;
                mp3si_pkg::LAYOUT_LSF_MONO:  hdr_len = mp3si_pkg::HDR_LEN_LSF_MONO;
                default:                     hdr_len = mp3si_pkg::HDR_LEN_LSF_STEREO;
            endcase
            rec_len = mpeg1 ? mp3si_pkg::REC_LEN_M1 : mp3si_pkg::REC_LEN_LSF;
            for (i = 7; i >= 0; i--) begin
                if (halted) break;
                sect_bits = {sect_bits[62:0], b[i]};
                bit_pos++;
                if (!in_recs) begin
                    if (bit_pos >= hdr_len) begin
                        h = sect_bits;
                        case ({mpeg1, mono})
                            mp3si_pkg::LAYOUT_M1_MONO: begin
                                ff_store = {h[17:9], h[8:4]};
                                scfsi    = {4'b0, h[3:0]};
                            end
                            mp3si_pkg::LAYOUT_M1_STEREO: begin
                                ff_store = {h[19:11], 2'b00, h[10:8]};
                                scfsi    = {h[3:0], h[7:4]};
                            end
                            mp3si_pkg::LAYOUT_LSF_MONO: begin
                                ff_store = {1'b0, h[8:1], 4'b0, h[0]};
                                scfsi    = '0;
                            end
                            default: begin
                                ff_store = {1'b0, h[9:2], 3'b0, h[1:0]};
                                scfsi    = '0;
                            end
                        endcase
                        in_recs   = 1'b1;
                        bit_pos   = 0;
                        sect_bits = '0;
                    end
                end else if (bit_pos >= rec_len && !emitted) begin
                    h   = sect_bits;
                    rec = '0;
                    if (mpeg1) begin
                        rec.part23      = h[58:47];
                        rec.big_vals    = h[46:38];
                        gain8           = h[37:30];
                        rec.sf_compress = {5'b0, h[29:26]};
                        ws              = h[25];
                        blk             = h[24:3];
                        pre             = h[2];
                        rec.idx         = mono ? {rec_cnt[0], 1'b0} : rec_cnt;
                        total           = mono ? 2 : 4;
                    end else begin
                        rec.part23      = h[62:51];
                        rec.big_vals    = h[50:42];
                        gain8           = h[41:34];
                        rec.sf_compress = h[33:25];
                        ws              = h[24];
                        blk             = h[23:2];
                        pre             = 1'b0;
                        rec.idx         = rec_cnt;
                        total           = mono ? 1 : 2;
                    end
                    scale = h[1];
                    c1    = h[0];
                    bt    = blk[21:20];
                    mixed = blk[19];
                    if (ws && bt == mp3si_pkg::BT_RESERVED) begin
                        // A reserved switched block kills the frame: only index and frame
                        // fields survive into the error record.
                        rec             = '0;
                        rec.idx         = mpeg1 ? (mono ? {rec_cnt[0], 1'b0} : rec_cnt)
                                                : rec_cnt;
                        rec.ffields     = ff_store;
                        rec.status      = mp3si_pkg::STATUS_ERROR;
                        halted          = 1'b1;
                    end else begin
                        if (ws) begin
                            rec.blk_info  = {1'b1, bt, mixed};
                            rec.tables    = {blk[18:14], blk[13:9], 5'b0};
                            rec.sub_gains = blk[8:0];
                            rec.regions   = (bt == mp3si_pkg::BT_SHORT && !mixed)
                                ? {mp3si_pkg::RC_SHORT_R0, mp3si_pkg::RC_SHORT_R1}
                                : {mp3si_pkg::RC_LONG_R0, mp3si_pkg::RC_LONG_R1};
                        end else begin
                            rec.tables  = blk[21:7];
                            rec.regions = {blk[6:3], 1'b0, blk[2:0]};
                        end
                        chan        = mpeg1 && !mono && rec_cnt[0];
                        rec.gain    = {1'b0, gain8} - mp3si_pkg::GAIN_OFFSET;
                        rec.gflags  = {chan ? scfsi[7:4] : scfsi[3:0], pre, scale, c1};
                        rec.ffields = ff_store;
                        if (int'(rec_cnt) + 1 >= total) begin
                            rec.status = mp3si_pkg::STATUS_LAST;
                            halted     = 1'b1;
                        end else begin
                            rec.status = mp3si_pkg::STATUS_RECORD;
                            rec_cnt    = rec_cnt + 2'd1;
                        end
                    end
                    expected_q.push_back(rec);
                    emitted   = 1'b1;
                    bit_pos   = 0;
                    sect_bits = '0;
                end
            end
            return consumed;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_record(t_granule_rec got);
            t_granule_rec want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected record, expected none, got index %0d status %0d",
                         $time, got.idx, got.status);
                return;
            end
            want = expected_q.pop_front();
            compare_field("record_index", want.idx, got.idx);
            compare_field("part23_length", want.part23, got.part23);
            compare_field("bigval_pairs", want.big_vals, got.big_vals);
            compare_field("gain_adj", want.gain, got.gain);
            compare_field("sf_compress", want.sf_compress, got.sf_compress);
            compare_field("block_info", want.blk_info, got.blk_info);
            compare_field("table_selects", want.tables, got.tables);
            compare_field("subblock_gains", want.sub_gains, got.sub_gains);
            compare_field("region_counts", want.regions, got.regions);
            compare_field("granule_flags", want.gflags, got.gflags);
            compare_field("frame_fields", want.ffields, got.ffields);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic [7:0]        i_data_byte   = 8'h00;
    logic              i_frame_start = 1'b0;
    logic              i_is_mono     = 1'b0;
    logic              i_is_mpeg1    = 1'b0;
    logic              i_ready       = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [1:0]        o_record_index;
    logic [11:0]       o_part23_length;
    logic [8:0]        o_bigval_pairs;
    logic signed [8:0] o_gain_adj;
    logic [8:0]        o_sf_compress;
    logic [3:0]        o_block_info;
    logic [14:0]       o_table_selects;
    logic [8:0]        o_subblock_gains;
    logic [7:0]        o_region_counts;
    logic [6:0]        o_granule_flags;
    logic [13:0]       o_frame_fields;
    logic [1:0]        o_status;

    t_granule_scoreboard sb;
    int                  live_words  = 0;
    bit                  quiet       = 1'b0;
    int unsigned         cycle_count = 0;

    mp3_side_info_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_frame_start    (i_frame_start),
        .i_is_mono        (i_is_mono),
        .i_is_mpeg1       (i_is_mpeg1),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_record_index   (o_record_index),
        .o_part23_length  (o_part23_length),
        .o_bigval_pairs   (o_bigval_pairs),
        .o_gain_adj       (o_gain_adj),
        .o_sf_compress    (o_sf_compress),
        .o_block_info     (o_block_info),
        .o_table_selects  (o_table_selects),
        .o_subblock_gains (o_subblock_gains),
        .o_region_counts  (o_region_counts),
        .o_granule_flags  (o_granule_flags),
        .o_frame_fields   (o_frame_fields),
        .o_status         (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_record({o_record_index, o_part23_length, o_bigval_pairs, o_gain_adj,
                             o_sf_compress, o_block_info, o_table_selects,
                             o_subblock_gains, o_region_counts, o_granule_flags,
                             o_frame_fields, o_status});
    end

    // Record sink: random back-pressure, plus one long hold-off once traffic is under way
    // so that the internal queue fills and the input side stalls.
    initial begin : record_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && live_words >= 300) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_word(logic [7:0] b, logic fs, logic m, logic m1);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_frame_start <= fs;
        i_is_mono     <= m;
        i_is_mpeg1    <= m1;
        do @(posedge i_clk); while (!o_ready);
        if (sb.note_word(b, fs, m, m1))
            live_words++;
    endtask

    // Waits until every expected record has come out; always advances the clock before it first checks.
    task automatic drain_records();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Builds one frame bit by bit and sends its first cut words. The record at err_rec,
    // if any, is made a switched block of the reserved type.
    task automatic send_frame(logic mono, logic mp1, int err_rec, int cut, int fill);
        logic        bitq[$];
        logic [63:0] sect;
        logic [7:0]  b;
        int          hdr_len, rec_len, n_rec, ws_at;
        int          i, r, k;
        hdr_len = mp1 ? (mono ? mp3si_pkg::HDR_LEN_M1_MONO : mp3si_pkg::HDR_LEN_M1_STEREO)
                      : (mono ? mp3si_pkg::HDR_LEN_LSF_MONO : mp3si_pkg::HDR_LEN_LSF_STEREO);
        rec_len = mp1 ? mp3si_pkg::REC_LEN_M1 : mp3si_pkg::REC_LEN_LSF;
        n_rec   = (mp1 ? 2 : 1) * (mono ? 1 : 2);
        ws_at   = mp1 ? 25 : 24;
        for (i = 0; i < hdr_len; i++)
            bitq.push_back(fill == FILL_ZERO ? 1'b0 :
                           fill == FILL_ONES ? 1'b1 : 1'($urandom_range(1)));
        for (r = 0; r < n_rec; r++) begin
            case (fill)
                FILL_ZERO: sect = '0;
                FILL_ONES: sect = '1;
                default:   sect = {$urandom, $urandom};
            endcase
            if (r == err_rec) begin
                sect[ws_at]           = 1'b1;
                sect[ws_at-1 -: 2]    = mp3si_pkg::BT_RESERVED;
            end else if (fill != FILL_RAW && sect[ws_at] &&
                         sect[ws_at-1 -: 2] == mp3si_pkg::BT_RESERVED) begin
                sect[ws_at-1 -: 2] = 2'($urandom_range(3, 1));
            end
            for (i = rec_len - 1; i >= 0; i--)
                bitq.push_back(sect[i]);
        end
        for (k = 0; k < bitq.size() / 8 && k < cut; k++) begin
            for (i = 0; i < 8; i++)
                b[7-i] = bitq[8*k+i];
            // Layout flags only matter on the first word; elsewhere they are noise.
            send_word(b, k == 0, (k == 0) ? mono : 1'($urandom_range(1)),
                      (k == 0) ? mp1 : 1'($urandom_range(1)));
        end
    endtask

    initial begin : stimulus
        int  sel, n;
        bit  paused;
        logic mono, mp1;
        sb     = new();
        paused = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Words before any frame start are ignored.
        send_word(8'hA5, 1'b0, 1'b1, 1'b0);
        send_word(8'h5A, 1'b0, 1'b0, 1'b1);
        send_frame(1'b1, 1'b0, NO_ERROR, WHOLE, FILL_ZERO);
        // A frame cut short and restarted by the next frame start.
        send_frame(1'b1, 1'b0, NO_ERROR, 4, FILL_LEGAL);
        send_frame(1'b1, 1'b0, NO_ERROR, WHOLE, FILL_ONES);
        // Reserved block type in the first record; the word after it is ignored.
        send_frame(1'b0, 1'b0, 0, 11, FILL_LEGAL);
        drain_records();

        while (live_words < TARGET_WORDS) begin
            quiet = (live_words >= 500 && live_words < 700);
            if (!paused && live_words >= 800) begin
                paused = 1'b1;
                drain_records();
            end
            sel  = $urandom_range(99);
            mono = 1'($urandom_range(1));
            mp1  = 1'($urandom_range(1));
            if (sel < 70) begin
                send_frame(mono, mp1, ($urandom_range(19) == 0) ? int'($urandom_range(3))
                                                                 : NO_ERROR,
                           WHOLE, FILL_LEGAL);
            end else if (sel < 80) begin
                send_frame(mono, mp1, NO_ERROR, $urandom_range(8, 1), FILL_LEGAL);
            end else if (sel < 88) begin
                send_frame(mono, mp1, NO_ERROR, WHOLE, FILL_RAW);
            end else if (sel < 92) begin
                send_frame(mono, mp1, NO_ERROR, WHOLE, ($urandom_range(1) == 0) ? FILL_ZERO
                                                                               : FILL_ONES);
            end else begin
                n = $urandom_range(6, 1);
                repeat (n)
                    send_word(8'($urandom_range(255)), $urandom_range(7) == 0,
                              1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
        quiet = 1'b0;

        drain_records();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- mp3_side_info_parser.f -----
rtl/core/mp3si_pkg.sv
rtl/core/mp3si_front.sv
rtl/core/mp3si_queue.sv
rtl/core/mp3si_back.sv
rtl/core/mp3_side_info_parser.sv
bench/tb_mp3_side_info_parser.sv
